>>> src/fpq_pkg.sv
// Package for the four-level priority queue: payload structs, record layout,
// status and level codes, and the urgency function.
// No dependencies.
`timescale 1ns / 1ps

package fpq_pkg;

    localparam int DEPTH_DEFAULT = 128;

    typedef enum logic [1:0] {
        LVL_RED    = 2'd0,
        LVL_ORANGE = 2'd1,
        LVL_YELLOW = 2'd2,
        LVL_GREEN  = 2'd3
    } level_t;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_FULL     = 2'd1,
        ST_SERVED   = 2'd2,
        ST_EMPTY    = 2'd3
    } status_t;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_REMOVE = 1'b1
    } cmd_t;

    typedef struct packed {
        logic        cmd;
        logic        imminent_risk;
        logic        significant_risk;
        logic        is_stable;
        logic        immediate_risk;
        logic [15:0] tag;
        logic [6:0]  age;
        logic [15:0] arrival;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [1:0]  level;
        logic [15:0] out_tag;
        logic [6:0]  out_age;
        logic [15:0] out_arrival;
        logic [7:0]  occupancy;
    } rsp_t;

    // one queued record, 41 bits
    typedef struct packed {
        logic [1:0]  level;
        logic [15:0] tag;
        logic [6:0]  age;
        logic [15:0] arrival;
    } rec_t;

    // controller -> datapath
    typedef struct packed {
        logic load;   // capture request transaction
        logic exec;   // apply operation, load result register
    } cmd_bus_t;

    // first decisive answer wins
    function automatic logic [1:0] urgency(input req_t r);
        logic [1:0] lv;
        if (r.imminent_risk)
            lv = LVL_RED;
        else if (r.significant_risk)
            lv = LVL_ORANGE;
        else if (!r.is_stable)
            lv = LVL_YELLOW;
        else if (r.immediate_risk)
            lv = LVL_YELLOW;
        else
            lv = LVL_GREEN;
        return lv;
    endfunction

endpackage

>>> src/fpq_ctrl.sv
// Controller for the priority queue: two-state sequencer and result valid.
// Depends on fpq_pkg.
`timescale 1ns / 1ps

module fpq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output fpq_pkg::cmd_bus_t cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   rsp_valid_reg, rsp_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg;
        req_ready      = 1'b0;
        cmd.load       = 1'b0;
        cmd.exec       = 1'b0;
        if (rsp_valid_reg && rsp_ready)
            rsp_valid_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                // hold until the result register is free
                if (!rsp_valid_reg || rsp_ready)
                begin
                    cmd.exec       = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;

endmodule

>>> src/fpq_datapath.sv
// Datapath for the priority queue: request register, row of record cells with
// parallel compare and shift, record count and result register.
// Depends on fpq_pkg.
`timescale 1ns / 1ps

module fpq_datapath #(
    parameter int DEPTH = fpq_pkg::DEPTH_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  fpq_pkg::cmd_bus_t cmd,
    input  fpq_pkg::req_t     req,
    output fpq_pkg::rsp_t     rsp
);

    localparam int CW = $clog2(DEPTH + 1);

    fpq_pkg::req_t req_reg;
    fpq_pkg::rsp_t rsp_reg, rsp_next;
    fpq_pkg::rec_t cell_reg  [DEPTH];
    fpq_pkg::rec_t cell_next [DEPTH];
    fpq_pkg::rec_t new_rec;
    logic [CW-1:0] count_reg, count_next;
    logic [DEPTH-1:0] le;
    logic [1:0] lvl;
    logic       full, empty, do_ins, do_rem;

    assign lvl   = fpq_pkg::urgency(req_reg);
    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign do_ins = cmd.exec && (req_reg.cmd == fpq_pkg::CMD_INSERT) && !full;
    assign do_rem = cmd.exec && (req_reg.cmd == fpq_pkg::CMD_REMOVE) && !empty;

    always_comb
    begin
        new_rec.level   = lvl;
        new_rec.tag     = req_reg.tag;
        new_rec.age     = req_reg.age;
        new_rec.arrival = req_reg.arrival;
    end

    // le is a prefix: occupied cells at least as urgent as the new record
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
            le[i] = (cell_reg[i].level <= lvl) && (CW'(i) < count_reg);
    end

    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            cell_next[i] = cell_reg[i];
            if (do_ins && !le[i])
            begin
                if (i == 0)
                    cell_next[i] = new_rec;
                else if (le[i-1])
                    cell_next[i] = new_rec;
                else
                    cell_next[i] = cell_reg[i-1];
            end
            else if (do_rem && (i < DEPTH - 1))
                cell_next[i] = cell_reg[i+1];
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (do_ins)
            count_next = count_reg + CW'(1);
        else if (do_rem)
            count_next = count_reg - CW'(1);
    end

    always_comb
    begin
        rsp_next             = '0;
        rsp_next.occupancy   = 8'(count_next);
        if (req_reg.cmd == fpq_pkg::CMD_INSERT)
        begin
            rsp_next.level  = lvl;
            rsp_next.status = full ? fpq_pkg::ST_FULL : fpq_pkg::ST_INSERTED;
        end
        else if (empty)
            rsp_next.status = fpq_pkg::ST_EMPTY;
        else
        begin
            rsp_next.status      = fpq_pkg::ST_SERVED;
            rsp_next.level       = cell_reg[0].level;
            rsp_next.out_tag     = cell_reg[0].tag;
            rsp_next.out_age     = cell_reg[0].age;
            rsp_next.out_arrival = cell_reg[0].arrival;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (cmd.exec)
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            req_reg <= req;
        if (cmd.exec)
            rsp_reg <= rsp_next;
        for (int i = 0; i < DEPTH; i++)
            cell_reg[i] <= cell_next[i];
    end

    assign rsp = rsp_reg;

endmodule

>>> src/four_level_priority_queue_unit.sv
// Four-level priority queue, top level: controller plus datapath.
// Depends on fpq_pkg, fpq_ctrl, fpq_datapath.
`timescale 1ns / 1ps

// Bounded queue of DEPTH records kept sorted by urgency (0 red .. 3 green),
// FIFO within a level. An insert (cmd 0) rates the record from the four risk
// answers and places it behind every record of equal or higher urgency, or
// reports full; a remove (cmd 1) returns the head record or reports empty.
// Each request transaction yields exactly one response transaction. An item is
// captured into the request register in S_IDLE; in S_EXEC every record
// cell compares and shifts in parallel and the result register is loaded.
// A new request is taken while an earlier response waits; the execute cycle
// waits only while the response register is still occupied.

module four_level_priority_queue_unit #(
    parameter int DEPTH = fpq_pkg::DEPTH_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  fpq_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output fpq_pkg::rsp_t rsp
);

    fpq_pkg::cmd_bus_t cmd;

    fpq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .cmd       (cmd)
    );

    fpq_datapath #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .req   (req),
        .rsp   (rsp)
    );

endmodule

>>> src/fpq_checker.sv
// Port-level checker for the priority queue, bound to the top level.
// Depends on fpq_pkg and four_level_priority_queue_unit.
`timescale 1ns / 1ps

module fpq_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_ready,
    input logic          rsp_valid,
    input logic          rsp_ready,
    input fpq_pkg::rsp_t rsp
);

    // response held while stalled
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    // one item in flight: no request taken right after one is taken
    a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while busy");

    // a response only follows a request transaction that has been taken
    a_rsp_follows: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> !req_ready || $past(!req_ready))
        else $error("response without request");

    // empty result carries no record
    a_empty_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == fpq_pkg::ST_EMPTY |->
            rsp.occupancy == 8'd0 && rsp.level == 2'd0 && rsp.out_tag == 16'd0)
        else $error("empty result not clean");

    // insert results carry no served record
    a_ins_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status == fpq_pkg::ST_INSERTED ||
                      rsp.status == fpq_pkg::ST_FULL) |->
            rsp.out_tag == 16'd0 && rsp.out_age == 7'd0 && rsp.out_arrival == 16'd0)
        else $error("insert result carries record fields");

endmodule

bind four_level_priority_queue_unit fpq_checker u_fpq_checker (.*);

>>> test/four_level_priority_queue_unit_tb.sv
// Testbench for four_level_priority_queue_unit: directed table, then random traffic
// scored against a behavioral sorted-queue predictor. Depends on fpq_pkg and the RTL.
`timescale 1ns / 1ps

module four_level_priority_queue_unit_tb;

    localparam int QUEUE_DEPTH   = fpq_pkg::DEPTH_DEFAULT;
    localparam int RANDOM_ITEMS  = 1900;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 20;
    localparam int MAX_REPORTS   = 10;

    typedef struct {
        fpq_pkg::req_t item;
        bit            spelled;   // result typed in below rather than predicted
        fpq_pkg::rsp_t result;
    } table_row_t;

    logic          clk = 1'b0;
    logic          rst_n;
    logic          req_valid;
    logic          req_ready;
    fpq_pkg::req_t req;
    logic          rsp_valid;
    logic          rsp_ready;
    fpq_pkg::rsp_t rsp;

    fpq_pkg::rec_t sorted_records[$];      // predicted queue contents, head first
    fpq_pkg::rsp_t awaited_responses[$];
    int            error_count = 0;
    int            items_sent = 0;
    int unsigned   hold_requests = 0;
    bit            tx_gaps_on = 1'b1;
    bit            rx_stall_on = 1'b1;

    four_level_priority_queue_unit #(
        .DEPTH(QUEUE_DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req      (req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp      (rsp)
    );

    always #1 clk = ~clk;

    function automatic fpq_pkg::req_t mk_req(input fpq_pkg::cmd_t c, input int imm,
                                             input int sig, input int stab, input int immed,
                                             input logic [15:0] tg, input logic [6:0] ag,
                                             input logic [15:0] arr);
        fpq_pkg::req_t r;
        r.cmd              = c;
        r.imminent_risk    = 1'(imm);
        r.significant_risk = 1'(sig);
        r.is_stable        = 1'(stab);
        r.immediate_risk   = 1'(immed);
        r.tag              = tg;
        r.age              = ag;
        r.arrival          = arr;
        return r;
    endfunction

    function automatic fpq_pkg::rsp_t mk_rsp(input fpq_pkg::status_t st,
                                             input fpq_pkg::level_t lv,
                                             input logic [15:0] tg, input logic [6:0] ag,
                                             input logic [15:0] arr, input logic [7:0] occ);
        fpq_pkg::rsp_t r;
        r.status      = st;
        r.level       = lv;
        r.out_tag     = tg;
        r.out_age     = ag;
        r.out_arrival = arr;
        r.occupancy   = occ;
        return r;
    endfunction

    function automatic fpq_pkg::level_t triage_level(input fpq_pkg::req_t r);
        fpq_pkg::level_t lv;
        if (r.imminent_risk)
            lv = fpq_pkg::LVL_RED;
        else if (r.significant_risk)
            lv = fpq_pkg::LVL_ORANGE;
        else if (!r.is_stable || r.immediate_risk)
            lv = fpq_pkg::LVL_YELLOW;
        else
            lv = fpq_pkg::LVL_GREEN;
        return lv;
    endfunction

    // Applies one transaction to the predicted queue and returns its response.
    function automatic fpq_pkg::rsp_t queue_response(input fpq_pkg::req_t r);
        fpq_pkg::rsp_t   res;
        fpq_pkg::rec_t   entry;
        fpq_pkg::level_t lv;
        int              pos;
        res = '0;
        if (r.cmd == fpq_pkg::CMD_INSERT)
        begin
            lv = triage_level(r);
            res.level = lv;
            if (sorted_records.size() >= QUEUE_DEPTH)
            begin
                res.status = fpq_pkg::ST_FULL;
            end
            else
            begin
                // behind every record of equal or higher urgency
                pos = sorted_records.size();
                while (pos > 0 && sorted_records[pos - 1].level > lv)
                    pos--;
                entry.level   = lv;
                entry.tag     = r.tag;
                entry.age     = r.age;
                entry.arrival = r.arrival;
                sorted_records.insert(pos, entry);
                res.status = fpq_pkg::ST_INSERTED;
            end
        end
        else if (sorted_records.size() == 0)
        begin
            res.status = fpq_pkg::ST_EMPTY;
        end
        else
        begin
            entry = sorted_records.pop_front();
            res.status      = fpq_pkg::ST_SERVED;
            res.level       = entry.level;
            res.out_tag     = entry.tag;
            res.out_age     = entry.age;
            res.out_arrival = entry.arrival;
        end
        res.occupancy = 8'(sorted_records.size());
        return res;
    endfunction

    // Mostly back-to-back, sometimes a short gap, rarely a long one.
    function automatic int idle_span();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return 0;
        else if (pick < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic fpq_pkg::req_t random_req(input int insert_pct);
        fpq_pkg::req_t r;
        r.cmd              = ($urandom_range(0, 99) < insert_pct) ?
                             fpq_pkg::CMD_INSERT : fpq_pkg::CMD_REMOVE;
        r.imminent_risk    = ($urandom_range(0, 3) == 0);
        r.significant_risk = ($urandom_range(0, 2) == 0);
        r.is_stable        = 1'($urandom_range(0, 1));
        r.immediate_risk   = 1'($urandom_range(0, 1));
        r.tag              = 16'($urandom_range(0, 16'hFFFF));
        r.age              = 7'($urandom_range(0, 127));
        r.arrival          = 16'($urandom_range(0, 16'hFFFF));
        return r;
    endfunction

    task automatic check_response(input fpq_pkg::rsp_t got);
        fpq_pkg::rsp_t want;
        bit            bad;
        if (awaited_responses.size() == 0)
        begin
            error_count++;
            if (error_count <= MAX_REPORTS)
                $display("%0t: response with none awaited: st=%0d lvl=%0d tag=%h occ=%0d",
                         $realtime, got.status, got.level, got.out_tag, got.occupancy);
        end
        else
        begin
            want = awaited_responses.pop_front();
            bad = (got.status !== want.status) || (got.level !== want.level)
                || (got.out_tag !== want.out_tag) || (got.out_age !== want.out_age)
                || (got.out_arrival !== want.out_arrival)
                || (got.occupancy !== want.occupancy);
            if (bad)
            begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display({"%0t: mismatch exp st=%0d lvl=%0d tag=%h age=%0d arr=%h occ=%0d",
                              " got st=%0d lvl=%0d tag=%h age=%0d arr=%h occ=%0d"},
                             $realtime, want.status, want.level, want.out_tag,
                             want.out_age, want.out_arrival, want.occupancy,
                             got.status, got.level, got.out_tag, got.out_age,
                             got.out_arrival, got.occupancy);
            end
        end
    endtask

    // Offers one transaction and waits for it to be taken; the expectation is
    // recorded at the accepting edge.
    task automatic offer_item(input fpq_pkg::req_t item, input bit spelled,
                              input fpq_pkg::rsp_t typed_rsp);
        int            gap;
        fpq_pkg::rsp_t predicted;
        gap = tx_gaps_on ? idle_span() : 0;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        predicted = queue_response(item);
        awaited_responses.push_back(spelled ? typed_rsp : predicted);
        items_sent++;
    endtask

    task automatic drain_pause();
        req_valid <= 1'b0;
        @(posedge clk);
        while (awaited_responses.size() != 0)
            @(posedge clk);
    endtask

    task automatic fill_phase();
        int extra;
        extra = $urandom_range(2, 6);
        while (sorted_records.size() < QUEUE_DEPTH)
            offer_item(random_req(100), 1'b0, '0);
        repeat (extra)
            offer_item(random_req(100), 1'b0, '0);
    endtask

    task automatic empty_phase();
        int extra;
        extra = $urandom_range(1, 3);
        while (sorted_records.size() > 0)
            offer_item(random_req(0), 1'b0, '0);
        repeat (extra)
            offer_item(random_req(0), 1'b0, '0);
    endtask

    task automatic mixed_phase(input int n);
        int pct;
        pct = $urandom_range(30, 70);
        repeat (n)
            offer_item(random_req(pct), 1'b0, '0);
    endtask

    // Receiver: stalls at random, honors long hold-offs, scores every response.
    initial
    begin : receiver
        int unsigned rx_wait;
        int unsigned holds_seen;
        rx_wait    = 0;
        holds_seen = 0;
        rsp_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_valid && rsp_ready)
                check_response(rsp);
            if (holds_seen != hold_requests)
            begin
                holds_seen = hold_requests;
                rx_wait    = HOLD_CYCLES;
            end
            else if (rx_wait == 0 && rx_stall_on && $urandom_range(0, 3) == 0)
            begin
                rx_wait = idle_span();
            end
            if (rx_wait > 0)
            begin
                rsp_ready <= 1'b0;
                rx_wait--;
            end
            else
            begin
                rsp_ready <= 1'b1;
            end
        end
    end

    initial
    begin : stimulus
        table_row_t plan[];
        int         phase;
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req       <= '0;

        plan = '{
            // remove on an empty queue
            '{mk_req(fpq_pkg::CMD_REMOVE, 1, 1, 1, 1, 16'hFFFF, 7'h7F, 16'hFFFF), 1'b1,
              mk_rsp(fpq_pkg::ST_EMPTY, fpq_pkg::LVL_RED, 16'h0, 7'h0, 16'h0, 8'd0)},
            // one insert per rating path, field extremes
            '{mk_req(fpq_pkg::CMD_INSERT, 0, 0, 1, 0, 16'h0000, 7'h00, 16'h0000), 1'b1,
              mk_rsp(fpq_pkg::ST_INSERTED, fpq_pkg::LVL_GREEN, 16'h0, 7'h0, 16'h0, 8'd1)},
            '{mk_req(fpq_pkg::CMD_INSERT, 0, 0, 1, 1, 16'hFFFF, 7'h7F, 16'hFFFF), 1'b1,
              mk_rsp(fpq_pkg::ST_INSERTED, fpq_pkg::LVL_YELLOW, 16'h0, 7'h0, 16'h0, 8'd2)},
            '{mk_req(fpq_pkg::CMD_INSERT, 0, 0, 0, 0, 16'h1234, 7'h2A, 16'h5678), 1'b1,
              mk_rsp(fpq_pkg::ST_INSERTED, fpq_pkg::LVL_YELLOW, 16'h0, 7'h0, 16'h0, 8'd3)},
            // later answers ignored once the level is settled
            '{mk_req(fpq_pkg::CMD_INSERT, 0, 1, 1, 1, 16'hBEEF, 7'h01, 16'h0001), 1'b1,
              mk_rsp(fpq_pkg::ST_INSERTED, fpq_pkg::LVL_ORANGE, 16'h0, 7'h0, 16'h0, 8'd4)},
            '{mk_req(fpq_pkg::CMD_INSERT, 1, 1, 1, 1, 16'h8001, 7'h40, 16'h8000), 1'b1,
              mk_rsp(fpq_pkg::ST_INSERTED, fpq_pkg::LVL_RED, 16'h0, 7'h0, 16'h0, 8'd5)},
            '{mk_req(fpq_pkg::CMD_INSERT, 1, 0, 0, 0, 16'h7FFE, 7'h3F, 16'h7FFF), 1'b1,
              mk_rsp(fpq_pkg::ST_INSERTED, fpq_pkg::LVL_RED, 16'h0, 7'h0, 16'h0, 8'd6)},
            '{mk_req(fpq_pkg::CMD_INSERT, 0, 0, 1, 0, 16'hA5A5, 7'h55, 16'h5A5A), 1'b1,
              mk_rsp(fpq_pkg::ST_INSERTED, fpq_pkg::LVL_GREEN, 16'h0, 7'h0, 16'h0, 8'd7)},
            // serve everything in urgency order, FIFO within a level
            '{mk_req(fpq_pkg::CMD_REMOVE, 0, 0, 0, 0, 16'h0000, 7'h00, 16'h0000), 1'b0, '0},
            '{mk_req(fpq_pkg::CMD_REMOVE, 1, 0, 1, 0, 16'hFFFF, 7'h7F, 16'hFFFF), 1'b0, '0},
            '{mk_req(fpq_pkg::CMD_REMOVE, 0, 1, 0, 1, 16'h1111, 7'h11, 16'h1111), 1'b0, '0},
            '{mk_req(fpq_pkg::CMD_REMOVE, 0, 0, 0, 0, 16'h0000, 7'h00, 16'h0000), 1'b0, '0},
            '{mk_req(fpq_pkg::CMD_REMOVE, 0, 0, 0, 0, 16'h0000, 7'h00, 16'h0000), 1'b0, '0},
            '{mk_req(fpq_pkg::CMD_REMOVE, 0, 0, 0, 0, 16'h0000, 7'h00, 16'h0000), 1'b0, '0},
            '{mk_req(fpq_pkg::CMD_REMOVE, 0, 0, 0, 0, 16'h0000, 7'h00, 16'h0000), 1'b0, '0},
            '{mk_req(fpq_pkg::CMD_REMOVE, 0, 0, 0, 0, 16'hFFFF, 7'h7F, 16'hFFFF), 1'b1,
              mk_rsp(fpq_pkg::ST_EMPTY, fpq_pkg::LVL_RED, 16'h0, 7'h0, 16'h0, 8'd0)},
            // a more urgent record overtakes queued ones
            '{mk_req(fpq_pkg::CMD_INSERT, 0, 1, 0, 0, 16'h000A, 7'h0A, 16'h000A), 1'b0, '0},
            '{mk_req(fpq_pkg::CMD_INSERT, 0, 1, 1, 0, 16'h000B, 7'h0B, 16'h000B), 1'b0, '0},
            '{mk_req(fpq_pkg::CMD_INSERT, 1, 0, 1, 1, 16'h000C, 7'h0C, 16'h000C), 1'b0, '0},
            '{mk_req(fpq_pkg::CMD_REMOVE, 0, 0, 0, 0, 16'h0000, 7'h00, 16'h0000), 1'b0, '0},
            '{mk_req(fpq_pkg::CMD_REMOVE, 0, 0, 0, 0, 16'h0000, 7'h00, 16'h0000), 1'b0, '0},
            '{mk_req(fpq_pkg::CMD_REMOVE, 0, 0, 0, 0, 16'h0000, 7'h00, 16'h0000), 1'b0, '0}
        };

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
            offer_item(plan[i].item, plan[i].spelled, plan[i].result);

        // guaranteed coverage first: full queue, long receiver hold-off with
        // the input backing up, sender pause, then drain to empty
        fill_phase();
        hold_requests++;
        tx_gaps_on = 1'b0;
        mixed_phase(24);
        tx_gaps_on = 1'b1;
        drain_pause();
        empty_phase();

        while (items_sent < RANDOM_ITEMS)
        begin
            tx_gaps_on  = ($urandom_range(0, 2) != 0);
            rx_stall_on = ($urandom_range(0, 2) != 0);
            phase = $urandom_range(0, 11);
            case (phase)
                0: fill_phase();
                1: empty_phase();
                2:
                begin
                    hold_requests++;
                    mixed_phase(20);
                end
                3: drain_pause();
                default: mixed_phase($urandom_range(20, 60));
            endcase
        end

        req_valid <= 1'b0;
        @(posedge clk);
        while (awaited_responses.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin : watchdog
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
